/* design/first_fit_heap_allocator_assert.svh */
// Assertion macros for the first-fit heap allocator.
// Expects clk and arst_n in the scope of the module that includes it.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
// same-cycle implication
`define FFHA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* design/ffha_pkg.sv */
// Package for the first-fit heap allocator: field widths, status codes,
// register indexes, reset values and the sequencer state type. No dependencies.
`default_nettype none
package ffha_pkg;
	localparam int MAX_BLOCKS_DEF   = 64;
	localparam int HEAP_LIMIT_DEF   = 1048576;
	localparam int PAGE_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 20;

	localparam int REQ_W  = 21;
	localparam int ADDR_W = 20;
	localparam int SIZE_W = 21;
	localparam int MINR_W = 13;

	typedef logic [1:0] status_t;
	localparam status_t STAT_OK      = 2'd0;
	localparam status_t STAT_LIMIT   = 2'd1;
	localparam status_t STAT_NOBLOCK = 2'd2;
	localparam status_t STAT_FULL    = 2'd3;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic REG_INIT = 1'b0;
	localparam logic REG_MINR = 1'b1;

	localparam logic [REQ_W-1:0]  INIT_HEAP_RST = 21'd65536;
	localparam logic [MINR_W-1:0] MINR_RST      = 13'd16;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_SC_RD, S_SC_EV, S_DIV, S_GROW, S_SPL, S_SH_RD, S_SH_WR,
		S_INS, S_MARK, S_F_RRD, S_F_REV, S_F_WR, S_RM_RD, S_RM_WR, S_DONE
	} state_t;
endpackage
`default_nettype wire

/* design/first_fit_heap_allocator.sv */
// First-fit heap allocator top level: block table memory and its sequencer.
// Depends on ffha_pkg and first_fit_heap_allocator_assert.svh.
//
// Usage: an item (action, request_bytes, free_address) is taken at a clock
// edge with start high and busy low. busy stays high until the result has
// been shown: status, address and granted_bytes are valid for exactly one
// cycle while done is high. The receiver cannot stall; done is not repeated.
// Operation: one table memory with one read port (registered data) walks the
// address-ordered block table, reading and then evaluating each entry. An
// allocate runs the first-fit scan, then on a miss the page rounding (a
// reciprocal multiply, a scale back to bytes, then the growth), and moves
// entries one by one, a read and a write each, when a split opens a slot.
// A free runs the scan and the merge, and moves entries up to close the gap.
// One item at a time.
// Reset: the block comes out of reset writing table entry 0 (init state,
// busy high) so the heap is one free block of initial_heap_bytes, capped at
// HEAP_LIMIT_BYTES. An APB write of initial_heap_bytes in idle repeats that step.
`default_nettype none
module first_fit_heap_allocator #(
	parameter int MAX_BLOCKS       = ffha_pkg::MAX_BLOCKS_DEF,
	parameter int HEAP_LIMIT_BYTES = ffha_pkg::HEAP_LIMIT_DEF,
	parameter int PAGE_BYTES       = ffha_pkg::PAGE_BYTES_DEF,
	parameter int HEADER_BYTES     = ffha_pkg::HEADER_BYTES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [2:0]                   paddr,
	input  wire  [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  wire                          start,
	output logic                         busy,
	input  wire                          action,
	input  wire  [ffha_pkg::REQ_W-1:0]   request_bytes,
	input  wire  [ffha_pkg::ADDR_W-1:0]  free_address,
	output logic                         done,
	output ffha_pkg::status_t            status,
	output logic [ffha_pkg::ADDR_W-1:0]  address,
	output logic [ffha_pkg::SIZE_W-1:0]  granted_bytes
);
	import ffha_pkg::*;

	localparam int SZW = $clog2(HEAP_LIMIT_BYTES + 1);
	localparam int CW  = ((SZW > REQ_W) ? SZW : REQ_W) + 3;
	localparam int DW  = CW + 17;
	localparam int BW  = $clog2(CW);
	localparam int IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int NW  = $clog2(MAX_BLOCKS + 1) + 1;
	localparam int PGL = $clog2(PAGE_BYTES);
	localparam int RSH = CW + PGL;
	localparam int RW  = CW + 1;
	localparam int PW  = 2 * CW + 1;

	localparam logic [CW-1:0] HDR  = CW'(HEADER_BYTES);
	localparam logic [CW-1:0] LIM  = CW'(HEAP_LIMIT_BYTES);
	localparam logic [CW-1:0] PGM1 = CW'(PAGE_BYTES - 1);
	localparam logic [CW-1:0] PGC  = CW'(PAGE_BYTES);
	localparam longint RECIP_L = ((longint'(1) << RSH) + longint'(PAGE_BYTES) - longint'(1))
		/ longint'(PAGE_BYTES);
	localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
	localparam logic [NW-1:0] MAXB = NW'(MAX_BLOCKS);
	localparam logic [NW-1:0] ONE  = NW'(1);

	// block table
	logic [SZW-1:0] mem_start [MAX_BLOCKS];
	logic [SZW-1:0] mem_bytes [MAX_BLOCKS];
	logic           mem_used  [MAX_BLOCKS];
	logic [SZW-1:0] rd_start, rd_bytes;
	logic           rd_used;
	logic           we;
	logic [IW-1:0]  wa, ra;
	logic [SZW-1:0] wd_start, wd_bytes;
	logic           wd_used;

	state_t state_q, nxt;
	logic [REQ_W-1:0]  init_q;
	logic [MINR_W-1:0] minr_q;
	logic [NW-1:0]     cnt_q, idx_q, k_q;
	logic [SZW-1:0]    top_q;
	logic              act_q;
	logic [REQ_W-1:0]  req_q;
	logic [ADDR_W-1:0] fad_q;
	logic [SZW-1:0]    cur_start_q, cur_bytes_q, prv_start_q, prv_bytes_q, rgt_bytes_q;
	logic              cur_used_q, prv_used_q, rgt_used_q, rgt_ok_q;
	logic [DW-1:0]     rem_q;
	logic [BW-1:0]     bit_q;
	logic [1:0]        rmv_q;
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [SIZE_W-1:0] res_granted_q;

	logic          cfg_wr;
	logic [CW-1:0] req_c, need_c, spl_need_c, x_c, grow_c, init_c, top_c, grow_top_c;
	logic [CW-1:0] ins_start_c, ins_bytes_c, data_addr_c, msum_c, ext_c;
	logic [SZW-1:0] sat_c;
	logic [PW-1:0] div_prod_c, div_quo_c;
	logic          hit, last, lim_fail, full_fail, do_split, lm, rm;
	logic [1:0]    r_c;
	logic [NW-1:0] idx1, idx2, p_c, p1, kr, km1;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MINR) ? 32'(minr_q) : 32'(init_q);

	assign req_c       = CW'(req_q);
	assign need_c      = req_c + HDR;
	assign spl_need_c  = req_c + HDR + HDR + CW'(minr_q);
	assign x_c         = req_c + HDR + HDR + PGM1;
	assign grow_c      = rem_q[CW-1:0];
	assign init_c      = CW'(init_q);
	assign sat_c       = (init_c > LIM) ? LIM[SZW-1:0] : init_c[SZW-1:0];
	assign top_c       = CW'(top_q);
	assign grow_top_c  = top_c + grow_c;
	assign ins_start_c = CW'(cur_start_q) + need_c;
	assign ins_bytes_c = CW'(cur_bytes_q) - req_c - HDR;
	assign data_addr_c = CW'(cur_start_q) + HDR;
	assign ext_c       = CW'(cur_bytes_q) + grow_c;
	// page count by reciprocal multiply, exact for every x below 2^CW
	assign div_prod_c  = PW'(x_c) * PW'(RECIP);
	assign div_quo_c   = div_prod_c >> RSH;

	assign idx1 = idx_q + ONE;
	assign idx2 = idx_q + NW'(2);
	assign km1  = k_q - ONE;
	assign kr   = k_q + NW'(rmv_q);

	assign hit = (act_q == ACT_FREE) ?
		((CW'(rd_start) + HDR) == CW'(fad_q)) :
		(!rd_used && (CW'(rd_bytes) >= need_c));
	assign last      = (idx1 == cnt_q);
	assign lim_fail  = grow_top_c > LIM;
	assign full_fail = cur_used_q && (cnt_q >= MAXB);
	assign do_split  = (CW'(cur_bytes_q) >= spl_need_c) && (cnt_q < MAXB);

	// merge with free neighbours on a free
	assign lm     = (idx_q != '0) && !prv_used_q;
	assign rm     = rgt_ok_q && !rgt_used_q;
	assign r_c    = {1'b0, lm} + {1'b0, rm};
	assign p_c    = lm ? (idx_q - ONE) : idx_q;
	assign p1     = p_c + ONE;
	assign msum_c = (lm ? CW'(prv_bytes_q) : '0) + CW'(cur_bytes_q)
		+ (rm ? CW'(rgt_bytes_q) : '0);

	always_ff @(posedge clk) begin
		if (we) begin
			mem_start[wa] <= wd_start;
			mem_bytes[wa] <= wd_bytes;
			mem_used[wa]  <= wd_used;
		end
		rd_start <= mem_start[ra];
		rd_bytes <= mem_bytes[ra];
		rd_used  <= mem_used[ra];
	end

	always_comb begin
		nxt = state_q;
		case (state_q)
			S_INIT: nxt = S_IDLE;
			S_IDLE: begin
				if (cfg_wr && paddr[2] == REG_INIT) nxt = S_INIT;
				else if (start) nxt = S_SC_RD;
			end
			S_SC_RD: nxt = S_SC_EV;
			S_SC_EV: begin
				if (hit) begin
					if (act_q == ACT_ALLOC) nxt = S_SPL;
					else if (!rd_used) nxt = S_DONE;
					else if (idx1 < cnt_q) nxt = S_F_RRD;
					else nxt = S_F_WR;
				end else if (last) begin
					nxt = (act_q == ACT_ALLOC) ? S_DIV : S_DONE;
				end else begin
					nxt = S_SC_RD;
				end
			end
			S_DIV: if (bit_q == '0) nxt = S_GROW;
			S_GROW: nxt = (lim_fail || full_fail) ? S_DONE : S_SPL;
			S_SPL: begin
				if (!do_split) nxt = S_MARK;
				else if (cnt_q > idx1) nxt = S_SH_RD;
				else nxt = S_INS;
			end
			S_SH_RD: nxt = S_SH_WR;
			S_SH_WR: nxt = (k_q == idx2) ? S_INS : S_SH_RD;
			S_INS:   nxt = S_MARK;
			S_MARK:  nxt = S_DONE;
			S_F_RRD: nxt = S_F_REV;
			S_F_REV: nxt = S_F_WR;
			S_F_WR: begin
				if (r_c != '0 && (p1 + NW'(r_c)) < cnt_q) nxt = S_RM_RD;
				else nxt = S_DONE;
			end
			S_RM_RD: nxt = S_RM_WR;
			S_RM_WR: nxt = ((kr + ONE) < cnt_q) ? S_RM_RD : S_DONE;
			S_DONE:  nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end

	always_comb begin
		we       = 1'b0;
		wa       = idx_q[IW-1:0];
		ra       = idx_q[IW-1:0];
		wd_start = cur_start_q;
		wd_bytes = cur_bytes_q;
		wd_used  = 1'b0;
		case (state_q)
			S_INIT: begin
				we       = 1'b1;
				wa       = '0;
				wd_start = '0;
				wd_bytes = sat_c;
			end
			S_GROW: begin
				if (!lim_fail && !full_fail) begin
					we = 1'b1;
					if (cur_used_q) begin
						wa       = cnt_q[IW-1:0];
						wd_start = top_q;
						wd_bytes = grow_c[SZW-1:0];
					end else begin
						wd_bytes = ext_c[SZW-1:0];
					end
				end
			end
			S_SH_RD: ra = km1[IW-1:0];
			S_SH_WR: begin
				we       = 1'b1;
				wa       = k_q[IW-1:0];
				wd_start = rd_start;
				wd_bytes = rd_bytes;
				wd_used  = rd_used;
			end
			S_INS: begin
				we       = 1'b1;
				wa       = idx1[IW-1:0];
				wd_start = ins_start_c[SZW-1:0];
				wd_bytes = ins_bytes_c[SZW-1:0];
			end
			S_MARK: begin
				we      = 1'b1;
				wd_used = 1'b1;
			end
			S_F_RRD: ra = idx1[IW-1:0];
			S_F_WR: begin
				we       = 1'b1;
				wa       = p_c[IW-1:0];
				wd_start = lm ? prv_start_q : cur_start_q;
				wd_bytes = msum_c[SZW-1:0];
			end
			S_RM_RD: ra = kr[IW-1:0];
			S_RM_WR: begin
				we       = 1'b1;
				wa       = k_q[IW-1:0];
				wd_start = rd_start;
				wd_bytes = rd_bytes;
				wd_used  = rd_used;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q  <= INIT_HEAP_RST;
			minr_q  <= MINR_RST;
			cnt_q   <= ONE;
			top_q   <= '0;
		end else begin
			state_q <= nxt;
			if (cfg_wr) begin
				if (paddr[2] == REG_MINR) minr_q <= pwdata[MINR_W-1:0];
				else init_q <= pwdata[REQ_W-1:0];
			end
			case (state_q)
				S_INIT: begin
					cnt_q <= ONE;
					top_q <= sat_c;
				end
				S_GROW: begin
					if (!lim_fail && !full_fail) begin
						top_q <= grow_top_c[SZW-1:0];
						if (cur_used_q) cnt_q <= cnt_q + ONE;
					end
				end
				S_INS:   cnt_q <= cnt_q + ONE;
				S_F_WR:  if (nxt == S_DONE) cnt_q <= cnt_q - NW'(r_c);
				S_RM_WR: if (nxt == S_DONE) cnt_q <= cnt_q - NW'(rmv_q);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q <= action;
				req_q <= request_bytes;
				fad_q <= free_address;
				idx_q <= '0;
			end
			S_SC_EV: begin
				prv_start_q <= cur_start_q;
				prv_bytes_q <= cur_bytes_q;
				prv_used_q  <= cur_used_q;
				cur_start_q <= rd_start;
				cur_bytes_q <= rd_bytes;
				cur_used_q  <= rd_used;
				rgt_ok_q    <= 1'b0;
				bit_q       <= BW'(1);
				res_addr_q  <= '0;
				if (hit && act_q == ACT_FREE) begin
					res_status_q  <= rd_used ? STAT_OK : STAT_NOBLOCK;
					res_granted_q <= rd_used ? SIZE_W'(rd_bytes) : '0;
				end else begin
					res_status_q  <= STAT_NOBLOCK;
					res_granted_q <= '0;
				end
				if (!hit && !last) idx_q <= idx1;
			end
			S_DIV: begin
				// pages for (req + 2 headers + page - 1), then back to bytes
				if (bit_q != '0) rem_q <= DW'(div_quo_c[CW-1:0]);
				else rem_q <= DW'(rem_q[CW-1:0] * PGC);
				bit_q <= bit_q - BW'(1);
			end
			S_GROW: begin
				res_addr_q    <= '0;
				res_granted_q <= '0;
				res_status_q  <= lim_fail ? STAT_LIMIT : STAT_FULL;
				if (cur_used_q) begin
					cur_start_q <= top_q;
					cur_bytes_q <= grow_c[SZW-1:0];
					cur_used_q  <= 1'b0;
					idx_q       <= cnt_q;
				end else begin
					cur_bytes_q <= ext_c[SZW-1:0];
				end
			end
			S_SPL:   k_q <= cnt_q;
			S_SH_WR: k_q <= km1;
			S_INS:   cur_bytes_q <= need_c[SZW-1:0];
			S_MARK: begin
				res_status_q  <= STAT_OK;
				res_addr_q    <= data_addr_c[ADDR_W-1:0];
				res_granted_q <= SIZE_W'(cur_bytes_q);
			end
			S_F_REV: begin
				rgt_bytes_q <= rd_bytes;
				rgt_used_q  <= rd_used;
				rgt_ok_q    <= 1'b1;
			end
			S_F_WR: begin
				k_q   <= p1;
				rmv_q <= r_c;
			end
			S_RM_WR: k_q <= k_q + ONE;
			default: k_q <= k_q;
		endcase
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = (state_q == S_DONE);
	assign status        = res_status_q;
	assign address       = res_addr_q;
	assign granted_bytes = res_granted_q;

`include "first_fit_heap_allocator_assert.svh"
	`FFHA_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "accepted item did not raise busy")
	`FFHA_ASSERT_SAME(a_cnt_range, 1'b1, cnt_q >= ONE && cnt_q <= MAXB, "block count out of range")
	`FFHA_ASSERT_SAME(a_fail_zero, done && status != STAT_OK, address == '0 && granted_bytes == '0, "failed item carries data")
	`FFHA_ASSERT_SAME(a_top_limit, 1'b1, CW'(top_q) <= LIM, "heap top beyond limit")
endmodule
`default_nettype wire
